// ===== design/pes_pkg.sv =====
// ----------------------------------------------------------------------------
// pes_pkg
// shared types and constants of the paired exchange sort
// ----------------------------------------------------------------------------
package pes_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int KEY_W     = 32;
    localparam int PAY_W     = 64;
    localparam int DATA_W    = KEY_W + PAY_W;

    typedef struct packed {
        logic [PAY_W-1:0] payload;
        logic [KEY_W-1:0] key;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } store_wr_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } store_rd_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FETCH_J,
        ST_TAKE_J,
        ST_SCAN,
        ST_PUT_J,
        ST_OUT_RD,
        ST_OUT_VALID
    } pes_state_t;

endpackage

// ===== design/pes_store.sv =====
// ----------------------------------------------------------------------------
// pes_store
// entry store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module pes_store
    import pes_pkg::*;
(
    input  logic      aclk,
    input  store_wr_t wr,
    input  store_rd_t rd,
    output entry_t    rd_data
);

    entry_t mem [MAX_ITEMS];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en) begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/paired_exchange_sort.sv =====
// ----------------------------------------------------------------------------
// paired_exchange_sort
// loads key/payload pairs, sorts them by signed key and streams them out
// ----------------------------------------------------------------------------
// Beats on the slave side are stored one per cycle into a 64-entry store
// (key and payload side by side). The beat with tlast set closes the list:
// the block then stops taking beats and runs an exchange sort on the stored
// entries with one signed 32-bit comparator and one store read and write per
// cycle. For each position j the entry at j is held in a register, every
// later entry is read in turn, and a strictly smaller one trades places with
// the held entry; the held entry is written back to j at the end of the pass.
// This gives exactly the tie order of the classic exchange sort. The scan of
// each position makes one compare per cycle, and each result beat is read
// from the registered store read before it is offered to the sink; the pace
// is set by the single store port pair. Beats beyond 64 entries are dropped
// and every result beat of that list then carries the overflow flag in tuser.
// After the last result beat the block is empty and takes a new list.
// ----------------------------------------------------------------------------
module paired_exchange_sort
    import pes_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // slave side
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // [31:0] sort_key, [95:32] payload_word
    input  logic              s_tlast,   // is_last
    // master side
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // [31:0] sorted_key, [95:32] sorted_payload
    output logic              m_tlast,   // final_entry
    output logic              m_tuser    // overflowed
);

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_ITEMS);

    pes_state_t       state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;       // entries held, also list length
    logic             ovf_reg, ovf_next;
    logic [IDX_W-1:0] j_reg, j_next;             // outer position / output index
    logic [IDX_W-1:0] i_reg, i_next;             // index of data coming out of the store
    entry_t           cur_reg, cur_next;         // entry held for position j

    store_wr_t        wr;
    store_rd_t        rd;
    entry_t           rd_data;

    logic             s_beat;
    logic             m_beat;
    logic [CNT_W-1:0] last_pos;
    logic             j_is_last;
    logic             i_is_last;
    logic             smaller;

    pes_store u_store (
        .aclk    (aclk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    assign s_beat    = s_tvalid && s_tready;
    assign m_beat    = m_tvalid && m_tready;
    assign last_pos  = fill_reg - CNT_W'(1);
    assign j_is_last = ({1'b0, j_reg} == last_pos);
    assign i_is_last = ({1'b0, i_reg} == last_pos);
    // the one shared comparator: signed key of store data against held key
    assign smaller   = ($signed(rd_data.key) < $signed(cur_reg.key));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (s_beat && s_tlast) begin
                    state_next = ST_FETCH_J;
                end
            end
            ST_FETCH_J: begin
                state_next = j_is_last ? ST_OUT_RD : ST_TAKE_J;
            end
            ST_TAKE_J: begin
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_is_last) begin
                    state_next = ST_PUT_J;
                end
            end
            ST_PUT_J: begin
                state_next = ST_FETCH_J;
            end
            ST_OUT_RD: begin
                state_next = ST_OUT_VALID;
            end
            ST_OUT_VALID: begin
                if (m_beat) begin
                    state_next = j_is_last ? ST_LOAD : ST_OUT_RD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // outputs, store ports and datapath
    always_comb begin
        s_tready  = 1'b0;
        m_tvalid  = 1'b0;
        wr        = '0;
        rd        = '0;
        fill_next = fill_reg;
        ovf_next  = ovf_reg;
        j_next    = j_reg;
        i_next    = i_reg;
        cur_next  = cur_reg;
        case (state_reg)
            ST_LOAD: begin
                s_tready = 1'b1;
                j_next   = '0;
                if (s_beat) begin
                    if (fill_reg < FULL_COUNT) begin
                        wr.en           = 1'b1;
                        wr.addr         = fill_reg[IDX_W-1:0];
                        wr.data.key     = s_tdata[KEY_W-1:0];
                        wr.data.payload = s_tdata[DATA_W-1:KEY_W];
                        fill_next       = fill_reg + CNT_W'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
            end
            ST_FETCH_J: begin
                // the last position has nothing after it: sorting is done
                if (j_is_last) begin
                    j_next = '0;
                end else begin
                    rd.en   = 1'b1;
                    rd.addr = j_reg;
                end
            end
            ST_TAKE_J: begin
                cur_next = rd_data;
                rd.en    = 1'b1;
                rd.addr  = j_reg + IDX_W'(1);
                i_next   = j_reg + IDX_W'(1);
            end
            ST_SCAN: begin
                if (smaller) begin
                    wr.en    = 1'b1;
                    wr.addr  = i_reg;
                    wr.data  = cur_reg;
                    cur_next = rd_data;
                end
                if (!i_is_last) begin
                    rd.en   = 1'b1;
                    rd.addr = i_reg + IDX_W'(1);
                    i_next  = i_reg + IDX_W'(1);
                end
            end
            ST_PUT_J: begin
                wr.en   = 1'b1;
                wr.addr = j_reg;
                wr.data = cur_reg;
                j_next  = j_reg + IDX_W'(1);
            end
            ST_OUT_RD: begin
                rd.en   = 1'b1;
                rd.addr = j_reg;
            end
            ST_OUT_VALID: begin
                m_tvalid = 1'b1;
                if (m_beat) begin
                    if (j_is_last) begin
                        fill_next = '0;
                        ovf_next  = 1'b0;
                        j_next    = '0;
                    end else begin
                        j_next = j_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // result beat comes straight from the registered store read
    assign m_tdata = {rd_data.payload, rd_data.key};
    assign m_tlast = j_is_last;
    assign m_tuser = ovf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            fill_reg  <= '0;
            ovf_reg   <= 1'b0;
            j_reg     <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            ovf_reg   <= ovf_next;
            j_reg     <= j_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg   <= i_next;
        cur_reg <= cur_next;
    end

    // never loading and emitting at once
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and output active together");

    // entry count never passes the store depth
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FULL_COUNT)
        else $error("fill count beyond store depth");

    // scan index stays after j and inside the list
    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (i_reg > j_reg) && ({1'b0, i_reg} < fill_reg))
        else $error("scan index out of range");

    // a list only ends with a non-empty store
    a_list_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_LOAD) |-> (fill_reg != '0))
        else $error("sorting an empty list");

    // last result beat empties the block
    a_list_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_beat && m_tlast) |=> (fill_reg == '0) && !ovf_reg && (state_reg == ST_LOAD))
        else $error("block not empty after last result");

endmodule

// ===== test/paired_exchange_sort_tb.sv =====
// ----------------------------------------------------------------------------
// paired_exchange_sort_tb
// self-checking bench for the paired exchange sort
// ----------------------------------------------------------------------------
// Lists of key/payload beats go in on the slave side. A shadow of the store
// mirrors each accepted beat. On the beat that closes a list, the shadow runs
// the same exchange sort (same swap order, so ties land where the hardware
// puts them) and queues the sorted beats. Every beat on the master side is
// compared with the oldest queued one.
// The run opens with a short directed table, one row per beat. Then come
// random lists in four traffic phases: no idling, a mostly idle sender, a
// mostly stalling sink, and light idling on both sides. There is also one
// long sink hold-off while the sender keeps pushing. A full list, an
// overflowing list and occasional long random lists exercise the capacity limit.
// ----------------------------------------------------------------------------
module paired_exchange_sort_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pes_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 6;
    localparam int RANDOM_BEATS   = 380;
    localparam int PHASES         = 4;
    localparam int HOLD_CYCLES    = 400;
    localparam int TAIL_CYCLES    = 300;
    // a full 64-entry sort runs with no beat moving on either side
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SHOWN_ERRORS   = 10;

    // one row of stimulus; typed rows carry their expected result beat
    typedef struct {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
        bit               last;
        bit               typed;
        logic [KEY_W-1:0] exp_key;
        logic [PAY_W-1:0] exp_payload;
    } stim_row_t;

    // one result beat as the sink should see it
    typedef struct {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
        bit               final_beat;
        bit               dropped;
    } sorted_beat_t;

    logic              aclk;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata  = '0;   // [31:0] sort_key, [95:32] payload_word
    logic              s_tlast  = 1'b0; // is_last
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;         // [31:0] sorted_key, [95:32] sorted_payload
    logic              m_tlast;         // final_entry
    logic              m_tuser;         // overflowed

    paired_exchange_sort u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // shadow of the block's store and list state
    logic [KEY_W-1:0] shadow_keys [MAX_ITEMS];
    logic [PAY_W-1:0] shadow_pays [MAX_ITEMS];
    int               shadow_fill;
    bit               shadow_dropped;
    int               list_beats;      // beats offered to the open list, dropped ones too

    sorted_beat_t     sorted_due [$];  // result beats still owed by the block

    // traffic knobs: idle and stall chances in percent per cycle, and the long hold-off
    int               tx_idle_pct   = 0;
    int               rx_stall_pct  = 0;
    int               hold_requests = 0;
    int               hold_served   = 0;
    int               hold_left     = 0;

    // bookkeeping
    int               fail_count    = 0;
    int               beats_checked = 0;
    int               lists_closed  = 0;
    int               lists_dropped = 0;
    int               longest_list  = 0;
    int               idle_cycles   = 0;

    // directed table: extremes first as one-entry lists, then short lists
    // that hit signed order at the edges, ties and already/reverse sorted input
    stim_row_t directed_rows [20] = '{
        // one-entry lists: the beat comes straight back, last set, no overflow
        '{32'h8000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1, 1, 32'h8000_0000, 64'hFFFF_FFFF_FFFF_FFFF},
        '{32'h7FFF_FFFF, 64'h0000_0000_0000_0000, 1, 1, 32'h7FFF_FFFF, 64'h0000_0000_0000_0000},
        '{32'h0000_0000, 64'hA5A5_5A5A_A5A5_5A5A, 1, 1, 32'h0000_0000, 64'hA5A5_5A5A_A5A5_5A5A},
        '{32'hFFFF_FFFF, 64'h0000_0000_0000_0001, 1, 1, 32'hFFFF_FFFF, 64'h0000_0000_0000_0001},
        // signed extremes mixed
        '{32'h7FFF_FFFF, 64'h0000_0000_0000_00A1, 0, 0, '0, '0},
        '{32'h8000_0000, 64'h0000_0000_0000_00A2, 0, 0, '0, '0},
        '{32'h0000_0000, 64'h0000_0000_0000_00A3, 0, 0, '0, '0},
        '{32'hFFFF_FFFF, 64'h0000_0000_0000_00A4, 0, 0, '0, '0},
        '{32'h0001_0000, 64'h0000_0000_0000_00A5, 1, 0, '0, '0},
        // tied keys, payloads show where the swaps leave them
        '{32'h0005_0000, 64'h1111_1111_1111_1111, 0, 0, '0, '0},
        '{32'h0003_0000, 64'h2222_2222_2222_2222, 0, 0, '0, '0},
        '{32'h0005_0000, 64'h3333_3333_3333_3333, 0, 0, '0, '0},
        '{32'h0003_0000, 64'h4444_4444_4444_4444, 0, 0, '0, '0},
        '{32'h0005_0000, 64'h5555_5555_5555_5555, 1, 0, '0, '0},
        // already in order
        '{32'hFFFF_0000, 64'hFEDC_BA98_7654_3210, 0, 0, '0, '0},
        '{32'h0001_0000, 64'h0123_4567_89AB_CDEF, 1, 0, '0, '0},
        // reverse order
        '{32'h0004_0000, 64'h0000_0000_0000_0004, 0, 0, '0, '0},
        '{32'h0003_0000, 64'h0000_0000_0000_0003, 0, 0, '0, '0},
        '{32'h0002_0000, 64'h0000_0000_0000_0002, 0, 0, '0, '0},
        '{32'h0001_0000, 64'h0000_0000_0000_0001, 1, 0, '0, '0}
    };

    initial begin
        aclk = 1'b0;
        forever #HALF_PERIOD aclk = ~aclk;
    end

    // mirror one accepted beat; on the closing beat sort and queue the list
    function automatic void store_and_sort(input stim_row_t row);
        logic [KEY_W-1:0] tk;
        logic [PAY_W-1:0] tp;
        sorted_beat_t     beat;
        list_beats++;
        if (shadow_fill < MAX_ITEMS) begin
            shadow_keys[shadow_fill] = row.key;
            shadow_pays[shadow_fill] = row.payload;
            shadow_fill++;
        end else begin
            shadow_dropped = 1'b1;   // store full, beat is lost
        end
        if (!row.last) return;
        // exchange sort: position j trades with every later strictly smaller key
        for (int j = 0; j < shadow_fill; j++) begin
            for (int i = j + 1; i < shadow_fill; i++) begin
                if ($signed(shadow_keys[i]) < $signed(shadow_keys[j])) begin
                    tk             = shadow_keys[i];
                    tp             = shadow_pays[i];
                    shadow_keys[i] = shadow_keys[j];
                    shadow_pays[i] = shadow_pays[j];
                    shadow_keys[j] = tk;
                    shadow_pays[j] = tp;
                end
            end
        end
        if (row.typed) begin
            // one-entry list with its result written in the table
            beat = '{row.exp_key, row.exp_payload, 1'b1, 1'b0};
            sorted_due.insert(sorted_due.size(), beat);
        end else begin
            for (int k = 0; k < shadow_fill; k++) begin
                beat = '{shadow_keys[k], shadow_pays[k], k == shadow_fill - 1, shadow_dropped};
                sorted_due.insert(sorted_due.size(), beat);
            end
        end
        lists_closed++;
        if (shadow_dropped) lists_dropped++;
        if (list_beats > longest_list) longest_list = list_beats;
        shadow_fill    = 0;
        shadow_dropped = 1'b0;
        list_beats     = 0;
    endfunction

    // offer one beat, with random idle cycles ahead of it, and wait for it to go in
    task automatic drive_beat(input stim_row_t row);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {row.payload, row.key};
        s_tlast  <= row.last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        store_and_sort(row);
    endtask

    // sink side: check each result beat, then pick tready for the next cycle
    always @(posedge aclk) begin
        sorted_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            beats_checked++;
            if (sorted_due.size() == 0) begin
                fail_count++;
                if (fail_count <= SHOWN_ERRORS)
                    $display("unexpected result beat: key=%h payload=%h last=%b ovf=%b",
                             m_tdata[KEY_W-1:0], m_tdata[DATA_W-1:KEY_W], m_tlast, m_tuser);
            end else begin
                want = sorted_due.pop_front();
                if (m_tdata[KEY_W-1:0] !== want.key ||
                    m_tdata[DATA_W-1:KEY_W] !== want.payload ||
                    m_tlast !== want.final_beat || m_tuser !== want.dropped) begin
                    fail_count++;
                    if (fail_count <= SHOWN_ERRORS) begin
                        $display("result beat %0d mismatch", beats_checked);
                        $display("  expected key=%h payload=%h last=%b ovf=%b",
                                 want.key, want.payload, want.final_beat, want.dropped);
                        $display("  actual   key=%h payload=%h last=%b ovf=%b",
                                 m_tdata[KEY_W-1:0], m_tdata[DATA_W-1:KEY_W], m_tlast,
                                 m_tuser);
                    end
                end
            end
        end
        if (hold_served != hold_requests) begin
            // long hold-off, counted here
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // watchdog: too long without any beat on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d result beats outstanding",
                     idle_cycles, sorted_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // stimulus
    initial begin
        stim_row_t row;
        int        phase_beats;
        int        list_len;
        bit        first_list;

        shadow_fill    = 0;
        shadow_dropped = 1'b0;
        list_beats     = 0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table, no idling
        foreach (directed_rows[n]) drive_beat(directed_rows[n]);

        for (int ph = 0; ph < PHASES; ph++) begin
            // sender pauses until the block has returned everything
            s_tvalid <= 1'b0;
            while (sorted_due.size() != 0) @(posedge aclk);
            case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 85; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 85; end
                default: begin
                    tx_idle_pct   = 10;
                    rx_stall_pct  = 10;
                    hold_requests = hold_requests + 1;  // sink holds off, source keeps going
                end
            endcase
            phase_beats = 0;
            first_list  = 1'b1;
            while (phase_beats < RANDOM_BEATS / PHASES) begin
                if (first_list && ph == 1)
                    list_len = MAX_ITEMS;               // exactly full
                else if (first_list && ph == 2)
                    list_len = MAX_ITEMS + 3;           // overflow, closing beat dropped
                else if ($urandom_range(99) < 4)
                    list_len = $urandom_range(MAX_ITEMS + 2, MAX_ITEMS - 4);
                else
                    list_len = $urandom_range(12, 1);
                first_list = 1'b0;
                for (int n = 0; n < list_len; n++) begin
                    case ($urandom_range(9))
                        0, 1: begin
                            case ($urandom_range(3))
                                0: row.key = 32'h8000_0000;
                                1: row.key = 32'h7FFF_FFFF;
                                2: row.key = 32'h0000_0000;
                                default: row.key = 32'hFFFF_FFFF;
                            endcase
                        end
                        2, 3, 4: row.key = $urandom_range(6) - 3;  // narrow range, many ties
                        default: row.key = $urandom;
                    endcase
                    row.payload     = {$urandom, $urandom};
                    row.last        = (n == list_len - 1);
                    row.typed       = 1'b0;
                    row.exp_key     = '0;
                    row.exp_payload = '0;
                    drive_beat(row);
                end
                phase_beats += list_len;
            end
        end

        // drain, then give the block time to show any stray beat
        s_tvalid <= 1'b0;
        while (sorted_due.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        fail_count += sorted_due.size();

        $display("sorted %0d lists (%0d with dropped beats, longest %0d beats)",
                 lists_closed, lists_dropped, longest_list);
        $display("checked %0d result beats under four idle/stall mixes and one long hold-off",
                 beats_checked);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d errors", fail_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
